[src/lca_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lca_pkg
// Shared types and constants for the Life grid block: opcodes, the 3x3
// neighbourhood window and the per-cell result of the shared evaluator.
// ----------------------------------------------------------------------------
package lca_pkg;

    // Operation codes carried on s_opcode
    typedef enum logic [1:0] {
        OP_STEP   = 2'd0,
        OP_TOGGLE = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // B3/S23 rule counts
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    // 3x3 neighbourhood: bit 2 is the left column, bit 1 the centre, bit 0 the right
    typedef struct packed {
        logic [2:0] above;
        logic [2:0] centre;
        logic [2:0] below;
    } win_t;

    // Evaluator result for one cell
    typedef struct packed {
        logic alive_next;
        logic changed;
    } cell_res_t;

endpackage

[src/lca_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lca_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lca_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

[src/lca_cell_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lca_cell_eval
// Shared cell evaluator: counts the eight neighbours in a 3x3 window and
// applies the B3/S23 rule to the centre cell. Used once per sweep cycle.
// ----------------------------------------------------------------------------
module lca_cell_eval (
    input  lca_pkg::win_t      win,
    output lca_pkg::cell_res_t res
);

    logic [3:0] n_count;
    logic       alive;
    logic       nxt;

    // Neighbour count (centre excluded)
    always_comb begin
        n_count = {3'b0, win.above[2]}  + {3'b0, win.above[1]}  + {3'b0, win.above[0]}
                + {3'b0, win.centre[2]} + {3'b0, win.centre[0]}
                + {3'b0, win.below[2]}  + {3'b0, win.below[1]}  + {3'b0, win.below[0]};
    end

    // Birth on three, survival on two or three
    assign alive = win.centre[1];
    assign nxt   = (n_count == lca_pkg::BIRTH_COUNT)
                 || (alive && (n_count == lca_pkg::SURVIVE_COUNT));

    assign res.alive_next = nxt;
    assign res.changed    = nxt ^ alive;

endmodule

[src/life_cellular_automaton_grid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_cellular_automaton_grid
// Bounded Game of Life grid (B3/S23) with generation count and stable flag.
// Step: one cell per cycle through the shared evaluator, plus row fetch/write per
//   row; a step while stable skips the sweep. Toggle/read: the addressed row is
//   read, and written back for a toggle; off the grid, no row access. Clear: the
//   row RAM is swept to zero. A result waiting for m_ready holds the block.
// One beat at a time; s_ready is low while a beat is in progress.
// Reset: synchronous active-low; the row RAM is then swept to zero, one row a
//   cycle, with s_ready held low.
// ----------------------------------------------------------------------------
module life_cellular_automaton_grid #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [5:0]  s_col,
    input  logic [5:0]  s_row,
    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_cell_alive,
    output logic [31:0] m_generation_count,
    output logic        m_is_stable
);

    localparam int CW = $clog2(GRID_WIDTH);
    localparam int AW = $clog2(GRID_HEIGHT);
    localparam int KW = $clog2(GRID_WIDTH + 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CLR   = 9'b000000010,
        S_RMW   = 9'b000000100,
        S_PRIME = 9'b000001000,
        S_FETCH = 9'b000010000,
        S_LOAD  = 9'b000100000,
        S_CALC  = 9'b001000000,
        S_WRITE = 9'b010000000,
        S_FIN   = 9'b100000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [AW-1:0]           row_reg, row_next;
    logic [KW-1:0]           k_reg, k_next;
    logic [CW-1:0]           col_reg, col_next;
    logic                    tog_reg, tog_next;
    logic [GRID_WIDTH-1:0]   above_reg, above_next;
    logic [GRID_WIDTH-1:0]   cur_reg, cur_next;
    logic [GRID_WIDTH-1:0]   below_reg, below_next;
    logic [GRID_WIDTH-1:0]   nrow_reg, nrow_next;
    lca_pkg::win_t           win_reg, win_next;
    logic                    changed_reg, changed_next;
    logic [31:0]             gen_reg, gen_next;
    logic                    stable_reg, stable_next;
    logic                    alive_reg, alive_next;
    logic                    clr_resp_reg, clr_resp_next;
    logic                    m_valid_reg, m_valid_next;
    logic                    m_alive_reg, m_alive_next;
    logic [31:0]             m_gen_reg, m_gen_next;
    logic                    m_stable_reg, m_stable_next;

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [GRID_WIDTH-1:0]   mem_wdata;
    logic [AW-1:0]           mem_raddr;
    logic [GRID_WIDTH-1:0]   mem_rdata;

    logic                    accept;
    logic                    on_grid;
    logic                    last_row;
    logic                    sweep_end;
    lca_pkg::win_t           win_shift;
    lca_pkg::cell_res_t      cell_res;
    logic                    rd_bit;

    // Row store: one row of cells per entry, bit c is column c
    lca_ram #(
        .WIDTH (GRID_WIDTH),
        .DEPTH (GRID_HEIGHT)
    ) u_grid_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // Shared evaluator sees the window after this cycle's shift
    lca_cell_eval u_cell_eval (
        .win (win_shift),
        .res (cell_res)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign on_grid   = (32'(s_col) < 32'(GRID_WIDTH)) && (32'(s_row) < 32'(GRID_HEIGHT));
    assign last_row  = (row_reg == AW'(GRID_HEIGHT - 1));
    assign sweep_end = (k_reg == KW'(GRID_WIDTH));
    assign rd_bit    = mem_rdata[col_reg];

    // Window shift: next column from each row, dead past the right edge
    always_comb begin
        if (sweep_end) begin
            win_shift.above  = {win_reg.above[1:0], 1'b0};
            win_shift.centre = {win_reg.centre[1:0], 1'b0};
            win_shift.below  = {win_reg.below[1:0], 1'b0};
        end else begin
            win_shift.above  = {win_reg.above[1:0], above_reg[0]};
            win_shift.centre = {win_reg.centre[1:0], cur_reg[0]};
            win_shift.below  = {win_reg.below[1:0], below_reg[0]};
        end
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        row_next      = row_reg;
        k_next        = k_reg;
        col_next      = col_reg;
        tog_next      = tog_reg;
        above_next    = above_reg;
        cur_next      = cur_reg;
        below_next    = below_reg;
        nrow_next     = nrow_reg;
        win_next      = win_reg;
        changed_next  = changed_reg;
        gen_next      = gen_reg;
        stable_next   = stable_reg;
        alive_next    = alive_reg;
        clr_resp_next = clr_resp_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_alive_next  = m_alive_reg;
        m_gen_next    = m_gen_reg;
        m_stable_next = m_stable_reg;
        mem_we        = 1'b0;
        mem_waddr     = row_reg;
        mem_wdata     = '0;
        mem_raddr     = row_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    alive_next = 1'b0;
                    case (lca_pkg::op_t'(s_opcode))
                        lca_pkg::OP_STEP: begin
                            if (stable_reg) begin
                                state_next = S_FIN;
                            end else begin
                                above_next   = '0;
                                row_next     = '0;
                                changed_next = 1'b0;
                                mem_raddr    = '0;
                                state_next   = S_PRIME;
                            end
                        end
                        lca_pkg::OP_TOGGLE, lca_pkg::OP_READ: begin
                            tog_next = (lca_pkg::op_t'(s_opcode) == lca_pkg::OP_TOGGLE);
                            col_next = CW'(s_col);
                            row_next = AW'(s_row);
                            if (on_grid) begin
                                mem_raddr  = AW'(s_row);
                                state_next = S_RMW;
                            end else begin
                                state_next = S_FIN;
                            end
                        end
                        lca_pkg::OP_CLEAR: begin
                            gen_next      = '0;
                            stable_next   = 1'b0;
                            row_next      = '0;
                            clr_resp_next = 1'b1;
                            state_next    = S_CLR;
                        end
                        default: begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            // Zero one row a cycle
            S_CLR: begin
                mem_we = 1'b1;
                if (last_row) begin
                    state_next = clr_resp_reg ? S_FIN : S_IDLE;
                end else begin
                    row_next = row_reg + AW'(1);
                end
            end

            // Read data of the addressed row is back; a toggle modifies and writes it back
            S_RMW: begin
                if (tog_reg) begin
                    mem_we      = 1'b1;
                    mem_wdata   = mem_rdata ^ ({{(GRID_WIDTH-1){1'b0}}, 1'b1} << col_reg);
                    alive_next  = !rd_bit;
                    stable_next = 1'b0;
                end else begin
                    alive_next  = rd_bit;
                end
                state_next = S_FIN;
            end

            // Row 0 is back; ask for row 1
            S_PRIME: begin
                cur_next   = mem_rdata;
                mem_raddr  = AW'(1);
                state_next = S_LOAD;
            end

            S_FETCH: begin
                mem_raddr  = row_reg + AW'(1);
                state_next = S_LOAD;
            end

            // Row below arrives; dead past the bottom edge
            S_LOAD: begin
                below_next = last_row ? '0 : mem_rdata;
                win_next   = '0;
                k_next     = '0;
                state_next = S_CALC;
            end

            // One cell per cycle; rows rotate so they are intact after the sweep
            S_CALC: begin
                win_next = win_shift;
                if (!sweep_end) begin
                    above_next = {above_reg[0], above_reg[GRID_WIDTH-1:1]};
                    cur_next   = {cur_reg[0], cur_reg[GRID_WIDTH-1:1]};
                    below_next = {below_reg[0], below_reg[GRID_WIDTH-1:1]};
                    k_next     = k_reg + KW'(1);
                end else begin
                    state_next = S_WRITE;
                end
                if (k_reg != '0) begin
                    nrow_next    = {cell_res.alive_next, nrow_reg[GRID_WIDTH-1:1]};
                    changed_next = changed_reg || cell_res.changed;
                end
            end

            // Store the new row and move the old-row window down
            S_WRITE: begin
                mem_we     = 1'b1;
                mem_wdata  = nrow_reg;
                above_next = cur_reg;
                cur_next   = below_reg;
                if (last_row) begin
                    if (changed_reg) begin
                        gen_next = gen_reg + 32'd1;
                    end
                    stable_next = !changed_reg;
                    state_next  = S_FIN;
                end else begin
                    row_next   = row_reg + AW'(1);
                    state_next = S_FETCH;
                end
            end

            // Hand the result to the output register once it is free
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_alive_next  = alive_reg;
                    m_gen_next    = gen_reg;
                    m_stable_next = stable_reg;
                    clr_resp_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            row_reg      <= '0;
            clr_resp_reg <= 1'b0;
            gen_reg      <= '0;
            stable_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            clr_resp_reg <= clr_resp_next;
            gen_reg      <= gen_next;
            stable_reg   <= stable_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        k_reg        <= k_next;
        col_reg      <= col_next;
        tog_reg      <= tog_next;
        above_reg    <= above_next;
        cur_reg      <= cur_next;
        below_reg    <= below_next;
        nrow_reg     <= nrow_next;
        win_reg      <= win_next;
        changed_reg  <= changed_next;
        alive_reg    <= alive_next;
        m_alive_reg  <= m_alive_next;
        m_gen_reg    <= m_gen_next;
        m_stable_reg <= m_stable_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_cell_alive       = m_alive_reg;
    assign m_generation_count = m_gen_reg;
    assign m_is_stable        = m_stable_reg;

    // Sweep counter never runs past the right edge
    a_sweep_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CALC) |-> (32'(k_reg) <= 32'(GRID_WIDTH)))
        else $error("column sweep overran the row");

    // Row store is written only by clear sweep, toggle or step write-back
    a_ram_write: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == S_CLR || state_reg == S_RMW || state_reg == S_WRITE))
        else $error("unexpected row store write");

    // Generation moves only at the end of a step or on a clear
    a_gen_change: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (gen_reg != $past(gen_reg))) |->
            ($past(state_reg == S_WRITE) ||
             ($past(accept) && $past(s_opcode) == lca_pkg::OP_CLEAR)))
        else $error("generation count changed outside a step or clear");

    // A result beat is raised only from the finish state
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $rose(m_valid_reg)) |-> $past(state_reg == S_FIN))
        else $error("result beat raised outside finish state");

endmodule
